>>> design/xcct_pkg.sv
// shared constants, types and the isotemperature line table
// no dependencies
package xcct_pkg;

    localparam int IN_W    = 16;
    localparam int KEL_W   = 20;
    localparam int ST_W    = 2;
    localparam int UV_W    = 17;
    localparam int LINES   = 31;
    localparam int IDX_W   = 5;
    localparam int DEN_W   = 21;
    localparam int DIST_W  = 43;
    localparam int MAG_W   = 42;
    localparam int MA_W    = 43;
    localparam int MB_W    = 25;
    localparam int MP_W    = MA_W + MB_W;
    localparam int DIV_W   = 56;
    localparam int LOW_W   = 20;
    localparam int STEP_W  = 5;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_BLACK = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [KEL_W-1:0] KEL_MAX = {KEL_W{1'b1}};
    localparam logic [UV_W-1:0]  UV_MAX  = {UV_W{1'b1}};
    localparam logic [MB_W-1:0]  MEGA    = 25'd1000000;

    typedef struct packed {
        logic [16:0]        u;
        logic [16:0]        v;
        logic signed [23:0] slope;
        logic [15:0]        norm;
        logic [9:0]         mired;
    } t_line;

    localparam t_line LINE_ROM [LINES] = '{
        '{17'd11800, 17'd17270, -24'sd15952,   16'd63677, 10'd0},
        '{17'd11840, 17'd17425, -24'sd16698,   16'd63507, 10'd10},
        '{17'd11884, 17'd17594, -24'sd17613,   16'd63290, 10'd20},
        '{17'd11933, 17'd17773, -24'sd18703,   16'd63020, 10'd30},
        '{17'd11989, 17'd17961, -24'sd19969,   16'd62690, 10'd40},
        '{17'd12051, 17'd18159, -24'sd21414,   16'd62295, 10'd50},
        '{17'd12120, 17'd18364, -24'sd23040,   16'd61827, 10'd60},
        '{17'd12197, 17'd18574, -24'sd24848,   16'd61279, 10'd70},
        '{17'd12281, 17'd18788, -24'sd26840,   16'd60647, 10'd80},
        '{17'd12373, 17'd19003, -24'sd29018,   16'd59925, 10'd90},
        '{17'd12473, 17'd19219, -24'sd31384,   16'd59108, 10'd100},
        '{17'd12755, 17'd19753, -24'sd38145,   16'd56640, 10'd125},
        '{17'd13082, 17'd20264, -24'sd46184,   16'd53570, 10'd150},
        '{17'd13451, 17'd20740, -24'sd55641,   16'd49959, 10'd175},
        '{17'd13856, 17'd21176, -24'sd66729,   16'd45921, 10'd200},
        '{17'd14291, 17'd21567, -24'sd79744,   16'd41610, 10'd225},
        '{17'd14753, 17'd21915, -24'sd95106,   16'd37186, 10'd250},
        '{17'd15235, 17'd22219, -24'sd113364,  16'd32800, 10'd275},
        '{17'd15735, 17'd22484, -24'sd135247,  16'd28578, 10'd300},
        '{17'd16248, 17'd22712, -24'sd161749,  16'd24610, 10'd325},
        '{17'd16771, 17'd22905, -24'sd194255,  16'd20950, 10'd350},
        '{17'd17302, 17'd23069, -24'sd234711,  16'd17625, 10'd375},
        '{17'd17838, 17'd23204, -24'sd285953,  16'd14640, 10'd400},
        '{17'd18376, 17'd23316, -24'sd352335,  16'd11984, 10'd425},
        '{17'd18916, 17'd23406, -24'sd440808,  16'd9637,  10'd450},
        '{17'd19454, 17'd23477, -24'sd563315,  16'd7573,  10'd475},
        '{17'd19992, 17'd23532, -24'sd742130,  16'd5765,  10'd500},
        '{17'd20526, 17'd23572, -24'sd1024197, 16'd4185,  10'd525},
        '{17'd21056, 17'd23600, -24'sd1528627, 16'd2807,  10'd550},
        '{17'd21582, 17'd23618, -24'sd2671903, 16'd1607,  10'd575},
        '{17'd22101, 17'd23626, -24'sd7631667, 16'd563,   10'd600}
    };

endpackage

>>> design/xcct_in_if.sv
// request channel carrying one xyz triple
// depends on xcct_pkg
interface xcct_in_if;
    logic                         valid;
    logic                         ready;
    logic [xcct_pkg::IN_W-1:0]    x_value;
    logic [xcct_pkg::IN_W-1:0]    y_value;
    logic [xcct_pkg::IN_W-1:0]    z_value;

    modport source (output valid, x_value, y_value, z_value, input ready);
    modport sink   (input valid, x_value, y_value, z_value, output ready);
endinterface

>>> design/xcct_out_if.sv
// result channel carrying kelvin and status
// depends on xcct_pkg
interface xcct_out_if;
    logic                         valid;
    logic                         ready;
    logic [xcct_pkg::KEL_W-1:0]   kelvin;
    logic [xcct_pkg::ST_W-1:0]    status;

    modport source (output valid, kelvin, status, input ready);
    modport sink   (input valid, kelvin, status, output ready);
endinterface

>>> design/xyz_to_correlated_color_temp.sv
// correlated color temperature of an xyz triple, robertson line walk
// depends on xcct_pkg, xcct_in_if, xcct_out_if, xcct_div, xcct_mul
//
// channel  dir  fields                        handshake
// i_in     in   x_value, y_value, z_value     valid/ready
// o_out    out  kelvin, status                valid/ready
//
// one request at a time; ready only while idle, a stalled result holds the block
// u and v each go through the serial divider, each table line through the shared
// multiplier, then interpolation and the final divide; a divide is skipped when u, v
// or kelvin saturates, and black input goes straight to the result
// reset is synchronous and clears only the sequencer and the divider's busy flag and step count
module xyz_to_correlated_color_temp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xcct_in_if.sink     i_in,
    xcct_out_if.source  o_out
);
    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_UST  = 15'b000000000000010,
        S_UWT  = 15'b000000000000100,
        S_VST  = 15'b000000000001000,
        S_VWT  = 15'b000000000010000,
        S_LMUL = 15'b000000000100000,
        S_LCHK = 15'b000000001000000,
        S_NA   = 15'b000000010000000,
        S_NB   = 15'b000000100000000,
        S_NC   = 15'b000001000000000,
        S_ND   = 15'b000010000000000,
        S_NE   = 15'b000100000000000,
        S_NF   = 15'b001000000000000,
        S_KWT  = 15'b010000000000000,
        S_OUT  = 15'b100000000000000
    } t_state;

    t_state r_state, n_state;

    logic [xcct_pkg::IN_W-1:0]     r_x, r_y, n_x, n_y;
    logic [xcct_pkg::DEN_W-1:0]    r_den, n_den;
    logic [xcct_pkg::UV_W-1:0]     r_u, r_v, n_u, n_v;
    logic [xcct_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic signed [xcct_pkg::DIST_W-1:0] r_d, r_dprev, n_d, n_dprev;
    logic [xcct_pkg::MAG_W-1:0]    r_a, r_b, n_a, n_b;
    logic [53:0]                   r_t, n_t;
    logic [53:0]                   r_den2, n_den2;
    logic [xcct_pkg::KEL_W-1:0]    r_kel, n_kel;
    logic [xcct_pkg::ST_W-1:0]     r_status, n_status;

    xcct_pkg::t_line               line_cur, line_prev;
    logic signed [xcct_pkg::MA_W-1:0] mul_a;
    logic signed [xcct_pkg::MB_W-1:0] mul_b;
    logic signed [xcct_pkg::MP_W-1:0] mul_p;

    logic                          div_start;
    logic [xcct_pkg::DIV_W-1:0]    div_rem, div_den;
    logic [xcct_pkg::LOW_W-1:0]    div_low;
    logic [xcct_pkg::STEP_W-1:0]   div_steps;
    logic                          div_busy;
    logic [xcct_pkg::LOW_W-1:0]    div_quot;

    logic [34:0]                   uv_num;
    logic signed [17:0]            du, dv;
    logic signed [xcct_pkg::DIST_W-1:0] d_calc;
    logic [xcct_pkg::MAG_W-1:0]    mag_cur, mag_prev, b_calc;
    logic [63:0]                   kn;

    xcct_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    xcct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_rem   (div_rem),
        .i_low   (div_low),
        .i_den   (div_den),
        .i_steps (div_steps),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    assign line_cur  = xcct_pkg::LINE_ROM[r_idx];
    assign line_prev = xcct_pkg::LINE_ROM[r_idx - 1'b1];

    always_comb begin
        du       = $signed({1'b0, r_u}) - $signed({1'b0, line_cur.u});
        dv       = $signed({1'b0, r_v}) - $signed({1'b0, line_cur.v});
        d_calc   = (xcct_pkg::DIST_W'(dv) <<< 16) - mul_p[xcct_pkg::DIST_W-1:0];
        mag_cur  = r_d[xcct_pkg::DIST_W-1] ? xcct_pkg::MAG_W'(-r_d) : xcct_pkg::MAG_W'(r_d);
        mag_prev = r_dprev[xcct_pkg::DIST_W-1] ? xcct_pkg::MAG_W'(-r_dprev)
                                               : xcct_pkg::MAG_W'(r_dprev);
        b_calc   = mul_p[57:16];
        if (r_state == S_UST) begin
            uv_num = 35'(r_x) << 18;
        end else begin
            uv_num = (35'(r_y) * 35'd6) << 16;
        end
        uv_num   = uv_num + 35'(r_den >> 1);
        kn       = 64'(mul_p[61:0]) + 64'(r_den2 >> 1);
    end

    always_comb begin
        n_state   = r_state;
        n_x       = r_x;
        n_y       = r_y;
        n_den     = r_den;
        n_u       = r_u;
        n_v       = r_v;
        n_idx     = r_idx;
        n_d       = r_d;
        n_dprev   = r_dprev;
        n_a       = r_a;
        n_b       = r_b;
        n_t       = r_t;
        n_den2    = r_den2;
        n_kel     = r_kel;
        n_status  = r_status;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        div_rem   = xcct_pkg::DIV_W'(uv_num >> 17);
        div_low   = {uv_num[16:0], 3'b000};
        div_den   = xcct_pkg::DIV_W'(r_den);
        div_steps = xcct_pkg::STEP_W'(17);

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_x   = i_in.x_value;
                    n_y   = i_in.y_value;
                    n_den = xcct_pkg::DEN_W'(i_in.x_value)
                          + (xcct_pkg::DEN_W'(i_in.y_value) << 4)
                          - xcct_pkg::DEN_W'(i_in.y_value)
                          + (xcct_pkg::DEN_W'(i_in.z_value) << 1)
                          + xcct_pkg::DEN_W'(i_in.z_value);
                    n_kel = '0;
                    if (i_in.x_value == '0 && i_in.y_value == '0 && i_in.z_value == '0) begin
                        n_status = xcct_pkg::ST_BLACK;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_UST;
                    end
                end
            end
            S_UST, S_VST: begin
                if ((uv_num >> 17) >= 35'(r_den)) begin
                    if (r_state == S_UST) begin
                        n_u     = xcct_pkg::UV_MAX;
                        n_state = S_VST;
                    end else begin
                        n_v     = xcct_pkg::UV_MAX;
                        n_idx   = '0;
                        n_state = S_LMUL;
                    end
                end else begin
                    div_start = 1'b1;
                    n_state   = (r_state == S_UST) ? S_UWT : S_VWT;
                end
            end
            S_UWT: begin
                if (!div_busy) begin
                    n_u     = div_quot[xcct_pkg::UV_W-1:0];
                    n_state = S_VST;
                end
            end
            S_VWT: begin
                if (!div_busy) begin
                    n_v     = div_quot[xcct_pkg::UV_W-1:0];
                    n_idx   = '0;
                    n_state = S_LMUL;
                end
            end
            S_LMUL: begin
                mul_a   = xcct_pkg::MA_W'(du);
                mul_b   = xcct_pkg::MB_W'(line_cur.slope);
                n_state = S_LCHK;
            end
            S_LCHK: begin
                n_d = d_calc;
                if (r_idx != '0 && (d_calc[xcct_pkg::DIST_W-1] != r_dprev[xcct_pkg::DIST_W-1])) begin
                    n_state = S_NA;
                end else begin
                    n_dprev = d_calc;
                    if (r_idx == xcct_pkg::IDX_W'(xcct_pkg::LINES - 1)) begin
                        n_kel    = '0;
                        n_status = xcct_pkg::ST_RANGE;
                        n_state  = S_OUT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_LMUL;
                    end
                end
            end
            S_NA: begin
                mul_a   = $signed({1'b0, mag_prev});
                mul_b   = $signed(xcct_pkg::MB_W'(line_prev.norm));
                n_state = S_NB;
            end
            S_NB: begin
                n_a     = mul_p[57:16];
                mul_a   = $signed({1'b0, mag_cur});
                mul_b   = $signed(xcct_pkg::MB_W'(line_cur.norm));
                n_state = S_NC;
            end
            S_NC: begin
                if (r_a == '0 && b_calc == '0) begin
                    n_b = xcct_pkg::MAG_W'(1);
                end else begin
                    n_b = b_calc;
                end
                mul_a   = $signed({1'b0, n_b});
                mul_b   = $signed(xcct_pkg::MB_W'(line_prev.mired));
                n_state = S_ND;
            end
            S_ND: begin
                n_t     = mul_p[53:0];
                mul_a   = $signed({1'b0, r_a});
                mul_b   = $signed(xcct_pkg::MB_W'(line_cur.mired));
                n_state = S_NE;
            end
            S_NE: begin
                n_den2  = r_t + mul_p[53:0];
                mul_a   = $signed({1'b0, r_a + r_b});
                mul_b   = $signed(xcct_pkg::MEGA);
                n_state = S_NF;
            end
            S_NF: begin
                n_status = xcct_pkg::ST_OK;
                if ((kn >> 20) >= 64'(r_den2)) begin
                    n_kel   = xcct_pkg::KEL_MAX;
                    n_state = S_OUT;
                end else begin
                    div_start = 1'b1;
                    div_rem   = xcct_pkg::DIV_W'(kn >> 20);
                    div_low   = kn[xcct_pkg::LOW_W-1:0];
                    div_den   = xcct_pkg::DIV_W'(r_den2);
                    div_steps = xcct_pkg::STEP_W'(xcct_pkg::LOW_W);
                    n_state   = S_KWT;
                end
            end
            S_KWT: begin
                if (!div_busy) begin
                    n_kel   = div_quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_y      <= n_y;
        r_den    <= n_den;
        r_u      <= n_u;
        r_v      <= n_v;
        r_idx    <= n_idx;
        r_d      <= n_d;
        r_dprev  <= n_dprev;
        r_a      <= n_a;
        r_b      <= n_b;
        r_t      <= n_t;
        r_den2   <= n_den2;
        r_kel    <= n_kel;
        r_status <= n_status;
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = (r_state == S_OUT);
    assign o_out.kelvin = r_kel;
    assign o_out.status = r_status;
endmodule

>>> design/xcct_div.sv
// restoring divider, one quotient bit per cycle
// depends on xcct_pkg
module xcct_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [xcct_pkg::DIV_W-1:0]     i_rem,
    input  logic [xcct_pkg::LOW_W-1:0]     i_low,
    input  logic [xcct_pkg::DIV_W-1:0]     i_den,
    input  logic [xcct_pkg::STEP_W-1:0]    i_steps,
    output logic                           o_busy,
    output logic [xcct_pkg::LOW_W-1:0]     o_quot
);
    logic                          r_busy;
    logic [xcct_pkg::STEP_W-1:0]   r_cnt;
    logic [xcct_pkg::DIV_W-1:0]    r_rem;
    logic [xcct_pkg::DIV_W-1:0]    r_den;
    logic [xcct_pkg::LOW_W-1:0]    r_low;
    logic [xcct_pkg::LOW_W-1:0]    r_quot;
    logic [xcct_pkg::DIV_W:0]      sh;
    logic                          qbit;
    logic [xcct_pkg::DIV_W-1:0]    n_rem;

    always_comb begin
        sh    = {r_rem, r_low[xcct_pkg::LOW_W-1]};
        qbit  = sh >= {1'b0, r_den};
        n_rem = qbit ? xcct_pkg::DIV_W'(sh - {1'b0, r_den}) : sh[xcct_pkg::DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == xcct_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem;
            r_den  <= i_den;
            r_low  <= i_low;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_low  <= {r_low[xcct_pkg::LOW_W-2:0], 1'b0};
            r_quot <= {r_quot[xcct_pkg::LOW_W-2:0], qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule

>>> design/xcct_mul.sv
// shared signed multiplier with registered product
// depends on xcct_pkg
module xcct_mul (
    input  logic                                i_clk,
    input  logic signed [xcct_pkg::MA_W-1:0]    i_a,
    input  logic signed [xcct_pkg::MB_W-1:0]    i_b,
    output logic signed [xcct_pkg::MP_W-1:0]    o_p
);
    logic signed [xcct_pkg::MP_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= xcct_pkg::MP_W'(i_a) * xcct_pkg::MP_W'(i_b);
    end

    assign o_p = r_p;
endmodule

>>> dv/tb.sv
// testbench for xyz_to_correlated_color_temp: directed and random xyz requests
// each result is checked against an in-bench robertson temperature predictor
// depends on xcct_pkg, xcct_in_if, xcct_out_if and the rtl top level
`timescale 1ns / 1ps
module tb;
    import xcct_pkg::*;

    typedef struct packed {
        logic [KEL_W-1:0] kelvin;
        logic [ST_W-1:0]  status;
    } t_cct;

    logic i_clk;
    logic i_rst_n;
    logic fail = 1'b0;
    logic hold_ready;
    int   stall_pct;
    int   idle_cycles;
    t_cct cct_expected [$];

    xcct_in_if  req_ch ();
    xcct_out_if res_ch ();

    xyz_to_correlated_color_temp uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [UV_W-1:0] chroma_q16(longint unsigned num, longint unsigned den);
        longint unsigned q;
        q = (num * 65536 + den / 2) / den;
        return (q > UV_MAX) ? UV_MAX : q[UV_W-1:0];
    endfunction

    function automatic longint signed iso_distance(logic [UV_W-1:0] u, logic [UV_W-1:0] v, int n);
        longint signed dv;
        longint signed du;
        dv = longint'(v) - longint'(LINE_ROM[n].v);
        du = longint'(u) - longint'(LINE_ROM[n].u);
        return dv * 65536 - longint'(LINE_ROM[n].slope) * du;
    endfunction

    function automatic longint unsigned scaled_mag(longint signed d, int n);
        longint unsigned m;
        m = (d < 0) ? longint'(-d) : d;
        return (m * LINE_ROM[n].norm) >> 16;
    endfunction

    function automatic t_cct predict_cct(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                                         logic [IN_W-1:0] z);
        t_cct r;
        longint unsigned den, a, b, kel;
        logic [UV_W-1:0] u, v;
        longint signed dprev, d;
        int i;
        bit found;
        r.kelvin = '0;
        dprev = 0;
        d = 0;
        found = 0;
        if (x == 0 && y == 0 && z == 0) begin
            r.status = ST_BLACK;
            return r;
        end
        den = longint'(x) + 15 * longint'(y) + 3 * longint'(z);
        u = chroma_q16(4 * longint'(x), den);
        v = chroma_q16(6 * longint'(y), den);
        for (i = 0; i < LINES; i++) begin
            d = iso_distance(u, v, i);
            if (i > 0 && ((d < 0) != (dprev < 0))) begin
                found = 1;
                break;
            end
            dprev = d;
        end
        if (!found) begin
            r.status = ST_RANGE;
            return r;
        end
        a = scaled_mag(dprev, i - 1);
        b = scaled_mag(d, i);
        if (a + b == 0) b = 1;
        den = longint'(LINE_ROM[i-1].mired) * b + longint'(LINE_ROM[i].mired) * a;
        if (den == 0) begin
            kel = KEL_MAX;
        end else begin
            kel = (1000000 * (a + b) + den / 2) / den;
            if (kel > KEL_MAX) kel = KEL_MAX;
        end
        r.kelvin = kel[KEL_W-1:0];
        r.status = ST_OK;
        return r;
    endfunction

    task automatic send_xyz(logic [IN_W-1:0] x, logic [IN_W-1:0] y, logic [IN_W-1:0] z);
        while (stall_pct > 0 && $urandom_range(99, 0) < stall_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.x_value <= x;
        req_ch.y_value <= y;
        req_ch.z_value <= z;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        cct_expected.push_back(predict_cct(x, y, z));
    endtask

    // random tint around the planckian locus, scaled
    task automatic send_near_locus();
        int t;
        int s;
        logic [IN_W-1:0] x, y, z;
        t = $urandom_range(LINES - 1, 0);
        s = $urandom_range(65535, 16);
        y = s[IN_W-1:0];
        x = IN_W'((longint'(s) * (2000 + $urandom_range(12000, 0))) / 10000);
        z = IN_W'((longint'(s) * (200 + t * 60 + $urandom_range(4000, 0))) / 10000);
        send_xyz(x, y, z);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (cct_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_xyz('0, '0, '0);
        send_xyz('1, '1, '1);
        send_xyz('1, '0, '0);
        send_xyz('0, '1, '0);
        send_xyz('0, '0, '1);
        send_xyz(16'd1, '0, '0);
        send_xyz('1, '1, '0);
        send_xyz('0, '1, '1);
        send_xyz('1, '0, '1);
        send_xyz(16'd57028, 16'd60000, 16'd65330);
        send_xyz(16'd55000, 16'd58000, 16'd63150);
        send_xyz(16'd64812, 16'd59000, 16'd20995);
        send_xyz(16'd63000, 16'd65535, 16'd50000);
        send_xyz(16'd60000, 16'd65535, 16'd130);
        send_xyz(16'd45000, 16'd65535, 16'd65535);
        send_xyz(16'd30000, 16'd65535, 16'd65535);
        send_xyz(16'd1, 16'd1, 16'd1);
        send_xyz(16'h5555, 16'hAAAA, 16'h5555);
        send_xyz(16'hAAAA, 16'h5555, 16'hAAAA);
    endtask

    task automatic test_random(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(3, 0) != 0) send_near_locus();
            else send_xyz(IN_W'($urandom_range(65535, 0)), IN_W'($urandom_range(65535, 0)),
                          IN_W'($urandom_range(65535, 0)));
        end
    endtask

    task automatic test_no_stall(int n);
        stall_pct = 0;
        test_random(n);
        stall_pct = 37;
    endtask

    always @(posedge i_clk) begin
        t_cct got;
        t_cct want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= hold_ready ? 1'b1 : ($urandom_range(99, 0) >= 37);
            if (res_ch.valid && res_ch.ready) begin
                got.kelvin = res_ch.kelvin;
                got.status = res_ch.status;
                if (cct_expected.size() == 0) begin
                    $display("%0t: unexpected result expected none actual kelvin %0d status %0d",
                             $time, got.kelvin, got.status);
                    fail <= 1'b1;
                end else begin
                    want = cct_expected.pop_front();
                    if (got.kelvin !== want.kelvin) begin
                        $display("%0t: kelvin expected %0d actual %0d",
                                 $time, want.kelvin, got.kelvin);
                        fail <= 1'b1;
                    end
                    if (got.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        fail <= 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        hold_ready     = 1'b0;
        stall_pct      = 37;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.x_value = '0;
        req_ch.y_value = '0;
        req_ch.z_value = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(700);
        wait_drained();
        hold_ready = 1'b1;
        test_no_stall(300);
        hold_ready = 1'b0;
        test_random(750);
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (!fail && cct_expected.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
